// ===== rtl/core/tkrt_pkg.sv =====
`default_nettype none

package tkrt_pkg;

  // Default number of table entries.
  localparam int unsigned TableDepthDefault = 8;

  // Fixed field widths of the transfer payload.
  localparam int unsigned RecTotalW  = 32;
  localparam int unsigned SlotTotalW = 31;
  localparam int unsigned RecScoreW  = 32;
  localparam int unsigned RecTimeW   = 24;
  localparam int unsigned ReadIdxW   = 3;
  localparam int unsigned RankW      = 3;
  localparam int unsigned FillW      = 4;

  // Request codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } tkrt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input transfer
    logic execute;  // run the request and load the result register
  } tkrt_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/top_k_record_table_unit.sv =====
`default_nettype none

// Top-k record table. Holds up to TableDepth records (total, score, time)
// sorted by descending total; on equal totals the older record stays ahead.
// An insert request (req_type 0) with a total of zero or less is dropped; any
// other record goes in front of the first held record with a smaller total,
// the entries below it move down one place and the last one falls off. A
// record that would land past the last place is not placed. Every request
// gives exactly one result: an insert reports placed and new_rank, a read
// (req_type 1) reports entry_valid and the record at read_index, zero fields
// when that place is empty; fill_count always shows the records now held.
// Timing: an item is latched on its input transfer and executed once the
// result register is free and takes its result; no new item is taken until
// the item has executed. The input register and the result register are
// separate, so the next item is taken while a result still waits for its
// output transfer; a stalled output holds the execute step until the result
// register frees up. All table cells compare with the new total in parallel
// and shift together. The table is empty after reset with no clearing pass.

module top_k_record_table_unit #(
  parameter int unsigned TableDepth = tkrt_pkg::TableDepthDefault
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  req_type_i,
  input  wire logic signed [tkrt_pkg::RecTotalW-1:0] rec_total_i,
  input  wire logic signed [tkrt_pkg::RecScoreW-1:0] rec_score_i,
  input  wire logic [tkrt_pkg::RecTimeW-1:0]         rec_time_i,
  input  wire logic [tkrt_pkg::ReadIdxW-1:0]         read_index_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic                                       placed_o,
  output logic [tkrt_pkg::RankW-1:0]                 new_rank_o,
  output logic                                       entry_valid_o,
  output logic [tkrt_pkg::SlotTotalW-1:0]            entry_total_o,
  output logic signed [tkrt_pkg::RecScoreW-1:0]      entry_score_o,
  output logic [tkrt_pkg::RecTimeW-1:0]              entry_time_o,
  output logic [tkrt_pkg::FillW-1:0]                 fill_count_o
);
  import tkrt_pkg::*;

  tkrt_cmd_t cmd;

  // Handshake sequencing: capture on input transfer, execute when the
  // result register is free.
  tkrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Table cells, compare-and-shift logic, read select and result register.
  tkrt_datapath #(
    .TableDepth (TableDepth)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (req_type_i),
    .rec_total_i   (rec_total_i),
    .rec_score_i   (rec_score_i),
    .rec_time_i    (rec_time_i),
    .read_index_i  (read_index_i),
    .placed_o      (placed_o),
    .new_rank_o    (new_rank_o),
    .entry_valid_o (entry_valid_o),
    .entry_total_o (entry_total_o),
    .entry_score_o (entry_score_o),
    .entry_time_o  (entry_time_o),
    .fill_count_o  (fill_count_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tkrt_ctrl.sv =====
`default_nettype none

module tkrt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tkrt_pkg::tkrt_cmd_t    cmd_o
);
  import tkrt_pkg::*;

  tkrt_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        exec_ok;

  // The result register is free when empty or being drained this cycle.
  assign exec_ok = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (exec_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_BUSY: begin
        cmd_o.execute = exec_ok;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tkrt_datapath.sv =====
`default_nettype none

module tkrt_datapath #(
  parameter int unsigned TableDepth = tkrt_pkg::TableDepthDefault
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire tkrt_pkg::tkrt_cmd_t                  cmd_i,
  input  wire logic                                 req_type_i,
  input  wire logic signed [tkrt_pkg::RecTotalW-1:0] rec_total_i,
  input  wire logic signed [tkrt_pkg::RecScoreW-1:0] rec_score_i,
  input  wire logic [tkrt_pkg::RecTimeW-1:0]        rec_time_i,
  input  wire logic [tkrt_pkg::ReadIdxW-1:0]        read_index_i,
  output logic                                      placed_o,
  output logic [tkrt_pkg::RankW-1:0]                new_rank_o,
  output logic                                      entry_valid_o,
  output logic [tkrt_pkg::SlotTotalW-1:0]           entry_total_o,
  output logic signed [tkrt_pkg::RecScoreW-1:0]     entry_score_o,
  output logic [tkrt_pkg::RecTimeW-1:0]             entry_time_o,
  output logic [tkrt_pkg::FillW-1:0]                fill_count_o
);
  import tkrt_pkg::*;

  localparam int unsigned IdxW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned WideW = (CntW > FillW) ? CntW : FillW;

  // Captured request
  logic                  req_q;
  logic [RecTotalW-1:0]  total_q;
  logic [RecScoreW-1:0]  score_q;
  logic [RecTimeW-1:0]   time_q;
  logic [ReadIdxW-1:0]   idx_q;

  // Table cells, kept sorted with the largest total at index 0
  logic [SlotTotalW-1:0] slot_total_q [TableDepth];
  logic [RecScoreW-1:0]  slot_score_q [TableDepth];
  logic [RecTimeW-1:0]   slot_time_q  [TableDepth];
  logic [CntW-1:0]       held_q, held_d;

  // Result register
  logic                  placed_q;
  logic [IdxW-1:0]       rank_q;
  logic                  ent_vld_q;
  logic [SlotTotalW-1:0] ent_total_q;
  logic [RecScoreW-1:0]  ent_score_q;
  logic [RecTimeW-1:0]   ent_time_q;
  logic [CntW-1:0]       fill_q;

  logic [SlotTotalW-1:0] ins_total;
  logic                  total_pos;
  logic                  ins_go;
  logic                  fits;
  logic [TableDepth-1:0] keep_ahead;
  logic [TableDepth-1:0] load;
  logic [TableDepth-1:0] shift;
  logic [IdxW-1:0]       rank;
  logic                  rd_valid;
  logic [SlotTotalW-1:0] rd_total;
  logic [RecScoreW-1:0]  rd_score;
  logic [RecTimeW-1:0]   rd_time;
  logic [WideW-1:0]      rank_ext;
  logic [WideW-1:0]      fill_ext;

  assign ins_total = total_q[SlotTotalW-1:0];
  assign total_pos = !total_q[RecTotalW-1] && (total_q != '0);
  assign ins_go    = cmd_i.execute && (req_q == REQ_INSERT) && total_pos;

  // Each cell compares its own total against the new one; a held entry with
  // an equal or larger total stays ahead of the newcomer.
  always_comb begin
    for (int k = 0; k < TableDepth; k++) begin
      keep_ahead[k] = (held_q > CntW'(k)) && (ins_total <= slot_total_q[k]);
    end
  end

  assign load[0]  = !keep_ahead[0];
  assign shift[0] = 1'b0;

  for (genvar k = 1; k < TableDepth; k++) begin : g_cell_ctl
    assign load[k]  = !keep_ahead[k] && keep_ahead[k-1];
    assign shift[k] = !keep_ahead[k] && !keep_ahead[k-1];
  end

  assign fits = !keep_ahead[TableDepth-1];

  always_comb begin
    rank = '0;
    for (int k = 0; k < TableDepth; k++) begin
      if (load[k]) begin
        rank = rank | IdxW'(k);
      end
    end
  end

  always_comb begin
    held_d = held_q;
    if (ins_go && fits && (held_q != CntW'(TableDepth))) begin
      held_d = held_q + CntW'(1);
    end
  end

  // Read port
  assign rd_valid = WideW'(idx_q) < WideW'(held_q);

  always_comb begin
    rd_total = '0;
    rd_score = '0;
    rd_time  = '0;
    for (int k = 0; k < TableDepth; k++) begin
      if (WideW'(k) == WideW'(idx_q)) begin
        rd_total = slot_total_q[k];
        rd_score = slot_score_q[k];
        rd_time  = slot_time_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_type_i;
      total_q <= rec_total_i;
      score_q <= rec_score_i;
      time_q  <= rec_time_i;
      idx_q   <= read_index_i;
    end
  end

  // Cell 0 only ever takes the new record; deeper cells take it or their
  // upper neighbour.
  always_ff @(posedge clk_i) begin
    if (ins_go && load[0]) begin
      slot_total_q[0] <= ins_total;
      slot_score_q[0] <= score_q;
      slot_time_q[0]  <= time_q;
    end
  end

  for (genvar k = 1; k < TableDepth; k++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (ins_go && load[k]) begin
        slot_total_q[k] <= ins_total;
        slot_score_q[k] <= score_q;
        slot_time_q[k]  <= time_q;
      end else if (ins_go && fits && shift[k]) begin
        slot_total_q[k] <= slot_total_q[k-1];
        slot_score_q[k] <= slot_score_q[k-1];
        slot_time_q[k]  <= slot_time_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      placed_q    <= ins_go && fits;
      rank_q      <= (ins_go && fits) ? rank : '0;
      ent_vld_q   <= (req_q == REQ_READ) && rd_valid;
      ent_total_q <= ((req_q == REQ_READ) && rd_valid) ? rd_total : '0;
      ent_score_q <= ((req_q == REQ_READ) && rd_valid) ? rd_score : '0;
      ent_time_q  <= ((req_q == REQ_READ) && rd_valid) ? rd_time : '0;
      fill_q      <= held_d;
    end
  end

  assign rank_ext = WideW'(rank_q);
  assign fill_ext = WideW'(fill_q);

  assign placed_o      = placed_q;
  assign new_rank_o    = rank_ext[RankW-1:0];
  assign entry_valid_o = ent_vld_q;
  assign entry_total_o = ent_total_q;
  assign entry_score_o = ent_score_q;
  assign entry_time_o  = ent_time_q;
  assign fill_count_o  = fill_ext[FillW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/tkrt_checker.sv =====
`default_nettype none

module tkrt_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_ready_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_ready_i,
  input wire logic                                 placed_o,
  input wire logic [tkrt_pkg::RankW-1:0]           new_rank_o,
  input wire logic                                 entry_valid_o,
  input wire logic [tkrt_pkg::SlotTotalW-1:0]      entry_total_o,
  input wire logic [tkrt_pkg::FillW-1:0]           fill_count_o
);

  // Hold the result while the output transfer is stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(placed_o)
      && $stable(new_rank_o) && $stable(fill_count_o))
    else $error("result changed while stalled");

  // The unit does not take input in the cycle after an input transfer.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on back-to-back cycles");

  // A nonzero rank only comes with a placed record.
  a_rank_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (new_rank_o != '0) |-> placed_o)
    else $error("rank without placement");

  // A valid read shows a positive total and no placement.
  a_read_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |-> !placed_o && (entry_total_o != '0)
      && (fill_count_o != '0))
    else $error("bad read result");

endmodule

bind top_k_record_table_unit tkrt_checker u_tkrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .placed_o      (placed_o),
  .new_rank_o    (new_rank_o),
  .entry_valid_o (entry_valid_o),
  .entry_total_o (entry_total_o),
  .fill_count_o  (fill_count_o)
);

`default_nettype wire

// ===== test/tb_top_k_record_table_unit.sv =====
`default_nettype none

module tb_top_k_record_table_unit;
  import tkrt_pkg::*;

  localparam int unsigned Depth      = TableDepthDefault;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRandom  = 450;
  localparam int unsigned PrintCap   = 60;

  // One request as the sender offers it; drain_first makes the sender wait
  // until every reply owed so far has arrived.
  typedef struct {
    logic                        req_type;
    logic signed [RecTotalW-1:0] total;
    logic signed [RecScoreW-1:0] score;
    logic [RecTimeW-1:0]         stamp;
    logic [ReadIdxW-1:0]         index;
    bit                          drain_first;
  } request_t;

  typedef struct {
    logic                        placed;
    logic [RankW-1:0]            rank;
    logic                        valid;
    logic [SlotTotalW-1:0]       total;
    logic signed [RecScoreW-1:0] score;
    logic [RecTimeW-1:0]         stamp;
    logic [FillW-1:0]            fill;
  } reply_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic                        req_type_i;
  logic signed [RecTotalW-1:0] rec_total_i;
  logic signed [RecScoreW-1:0] rec_score_i;
  logic [RecTimeW-1:0]         rec_time_i;
  logic [ReadIdxW-1:0]         read_index_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic                        placed_o;
  logic [RankW-1:0]            new_rank_o;
  logic                        entry_valid_o;
  logic [SlotTotalW-1:0]       entry_total_o;
  logic signed [RecScoreW-1:0] entry_score_o;
  logic [RecTimeW-1:0]         entry_time_o;
  logic [FillW-1:0]            fill_count_o;

  top_k_record_table_unit #(
    .TableDepth(Depth)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .rec_total_i  (rec_total_i),
    .rec_score_i  (rec_score_i),
    .rec_time_i   (rec_time_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .placed_o     (placed_o),
    .new_rank_o   (new_rank_o),
    .entry_valid_o(entry_valid_o),
    .entry_total_o(entry_total_o),
    .entry_score_o(entry_score_o),
    .entry_time_o (entry_time_o),
    .fill_count_o (fill_count_o)
  );

  // Shadow copy of the ranked table, kept in step with accepted requests.
  logic [SlotTotalW-1:0]       shadow_total [Depth];
  logic signed [RecScoreW-1:0] shadow_score [Depth];
  logic [RecTimeW-1:0]         shadow_stamp [Depth];
  int unsigned                 shadow_fill;

  request_t    requests_to_send[$];
  reply_t      replies_due[$];
  int unsigned replies_owed;
  int unsigned sent_count;
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  bit          hold_done;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Apply one request to the shadow table and return the reply it should give.
  function automatic reply_t rank_or_fetch(request_t rq);
    reply_t      rp;
    int unsigned pos;
    int unsigned last;
    rp = '{default: '0};
    if (rq.req_type == REQ_INSERT) begin
      // only strictly positive totals take part
      if (!rq.total[RecTotalW-1] && rq.total != 0) begin
        pos = 0;
        while (pos < shadow_fill && rq.total[SlotTotalW-1:0] <= shadow_total[pos]) pos++;
        if (pos < Depth) begin
          last = (shadow_fill < Depth) ? shadow_fill : Depth - 1;
          for (int unsigned k = last; k > pos; k--) begin
            shadow_total[k] = shadow_total[k-1];
            shadow_score[k] = shadow_score[k-1];
            shadow_stamp[k] = shadow_stamp[k-1];
          end
          shadow_total[pos] = rq.total[SlotTotalW-1:0];
          shadow_score[pos] = rq.score;
          shadow_stamp[pos] = rq.stamp;
          if (shadow_fill < Depth) shadow_fill++;
          rp.placed = 1'b1;
          rp.rank   = RankW'(pos);
        end
      end
    end else if (rq.index < shadow_fill) begin
      rp.valid = 1'b1;
      rp.total = shadow_total[rq.index];
      rp.score = shadow_score[rq.index];
      rp.stamp = shadow_stamp[rq.index];
    end
    rp.fill = FillW'(shadow_fill);
    return rp;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatch_count < PrintCap)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_request(logic kind, logic signed [RecTotalW-1:0] total,
                               logic signed [RecScoreW-1:0] score,
                               logic [RecTimeW-1:0] stamp, logic [ReadIdxW-1:0] index,
                               bit drain_first);
    request_t rq;
    rq.req_type    = kind;
    rq.total       = total;
    rq.score       = score;
    rq.stamp       = stamp;
    rq.index       = index;
    rq.drain_first = drain_first;
    requests_to_send.insert(requests_to_send.size(), rq);
  endtask

  // Idle rates by phase: sender light and receiver heavy, then the reverse,
  // then flat out.
  always_comb begin
    if (sent_count < 170) begin
      send_idle_pct = 22;
      recv_idle_pct = 88;
    end else if (sent_count < 330) begin
      send_idle_pct = 88;
      recv_idle_pct = 22;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Sender: hold the payload until its transfer, then offer the next request
  // unless it idles or must wait for the pipeline to empty.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    request_t rq;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      req_type_i   <= REQ_INSERT;
      rec_total_i  <= '0;
      rec_score_i  <= '0;
      rec_time_i   <= '0;
      read_index_i <= '0;
      sent_count   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) sent_count <= sent_count + 1;
      if (!in_valid_i || in_ready_o) begin
        if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            (!requests_to_send[0].drain_first ||
             (replies_owed == 0 && !(in_valid_i && in_ready_o)))) begin
          rq = requests_to_send.pop_front();
          in_valid_i   <= 1'b1;
          req_type_i   <= rq.req_type;
          rec_total_i  <= rq.total;
          rec_score_i  <= rq.score;
          rec_time_i   <= rq.stamp;
          read_index_i <= rq.index;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off late in the run: the sender keeps offering, so the
  // block fills both registers and must stall its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= 380) begin
      hold_left <= 70;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check each reply transfer against the oldest prediction, then predict the
  // reply for any request transfer on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch_transfers
    reply_t want;
    if (!rst_ni) begin
      replies_owed <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected reply, fill", fill_count_o, 0);
        end else begin
          want = replies_due.pop_front();
          if (placed_o !== want.placed) report_mismatch("placed", placed_o, want.placed);
          if (new_rank_o !== want.rank) report_mismatch("new_rank", new_rank_o, want.rank);
          if (entry_valid_o !== want.valid)
            report_mismatch("entry_valid", entry_valid_o, want.valid);
          if (entry_total_o !== want.total)
            report_mismatch("entry_total", entry_total_o, want.total);
          if (entry_score_o !== want.score)
            report_mismatch("entry_score", entry_score_o, want.score);
          if (entry_time_o !== want.stamp)
            report_mismatch("entry_time", entry_time_o, want.stamp);
          if (fill_count_o !== want.fill)
            report_mismatch("fill_count", fill_count_o, want.fill);
        end
      end
      if (in_valid_i && in_ready_o)
        replies_due.insert(replies_due.size(),
                           rank_or_fetch('{req_type: req_type_i, total: rec_total_i,
                                           score: rec_score_i, stamp: rec_time_i,
                                           index: read_index_i, drain_first: 1'b0}));
      replies_owed <= replies_owed + 32'(in_valid_i && in_ready_o)
                                   - 32'(out_valid_o && out_ready_i);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : run_test
    logic                        kind;
    logic signed [RecTotalW-1:0] total;
    int unsigned                 pick;
    shadow_fill    = 0;
    mismatch_count = 0;
    rst_ni         = 1'b0;

    // Directed: empty reads, dropped totals, ties, filling up, a record out of
    // rank, a mid-table insert that pushes the last entry out, then read every place.
    queue_request(REQ_READ, 0, 0, 0, 3'd0, 1'b0);
    queue_request(REQ_READ, 0, 0, 0, 3'd7, 1'b0);
    queue_request(REQ_INSERT, 0, 32'sh7fffffff, 24'hffffff, 3'd7, 1'b0);
    queue_request(REQ_INSERT, -1, -1, 24'hffffff, 3'd0, 1'b0);
    queue_request(REQ_INSERT, 32'sh80000000, 32'sh80000000, 24'hffffff, 3'd5, 1'b0);
    queue_request(REQ_INSERT, 100, 32'sh7fffffff, 24'hffffff, 3'd0, 1'b0);
    queue_request(REQ_INSERT, 100, 32'sh80000000, 24'h000000, 3'd7, 1'b0);
    queue_request(REQ_INSERT, 32'sh7fffffff, -1, 24'h000001, 3'd2, 1'b0);
    queue_request(REQ_INSERT, 1, 0, 24'h000100, 3'd0, 1'b0);
    queue_request(REQ_INSERT, 50, 12345, 24'h0a5a5a, 3'd0, 1'b0);
    queue_request(REQ_INSERT, 200, -777, 24'h5a5a5a, 3'd0, 1'b0);
    queue_request(REQ_INSERT, 100, 42, 24'h123456, 3'd0, 1'b0);
    queue_request(REQ_INSERT, 7, 9, 24'h800000, 3'd0, 1'b0);
    queue_request(REQ_INSERT, 1, 1, 24'h000001, 3'd0, 1'b0);
    queue_request(REQ_INSERT, 150, 150, 24'h00ff00, 3'd0, 1'b0);
    queue_request(REQ_INSERT, 2, 2, 24'h000002, 3'd0, 1'b0);
    for (int i = 0; i < Depth; i++)
      queue_request(REQ_READ, 0, 0, 0, ReadIdxW'(i), i == 0);

    // Random: mostly positive totals that creep upwards with small spread, so
    // records land on every rank, tie and fall out of rank; some dropped
    // totals and a few huge ones.
    for (int i = 0; i < NumRandom; i++) begin
      kind = ($urandom_range(0, 99) < 60) ? REQ_INSERT : REQ_READ;
      pick = $urandom_range(0, 99);
      if (pick < 10) total = (pick < 3) ? 0 : ($urandom() | 32'h80000000);
      else if (pick < 13) total = ($urandom() & 32'h7fffffff) | 32'h1;
      else total = 32'(i * 16 + $urandom_range(1, 48));
      queue_request(kind, total, $urandom(), RecTimeW'($urandom_range(0, 24'hffffff)),
                    ReadIdxW'($urandom_range(0, 7)), (i % 97) == 50);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last request transfer, then for every reply owed.
    while (requests_to_send.size() != 0 || in_valid_i) @(posedge clk_i);
    while (replies_owed != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0 && replies_due.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
